// File: src/qalu_pkg.sv
// shared types and constants for the q16 fixed point unit
package qalu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW = 32;
	// dividend magnitude width: |a| shifted left by the fraction bits
	localparam int NW = DW + FRAC_BITS;
	// one quotient bit per cell
	localparam int NCELL = NW;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_CONV = 2'd2,
		OP_ABS = 2'd3
	} op_t;

	// item traveling along the cell row
	typedef struct packed {
		logic          vld;
		logic [31:0]   res;
		logic          ovf;
		logic          dz;
		logic          is_div;
		logic          neg;
		logic [NW-1:0] num;
		logic [DW:0]   rem;
		logic [NW-1:0] quo;
		logic [DW-1:0] den;
	} cell_t;

endpackage

// File: src/qalu_front.sv
// front stage: decodes the operation, computes multiply, convert and abs, prepares divide
module qalu_front
	import qalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [1:0]  operation,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output cell_t       dout
);

	logic [1:0]  op_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic        vld_s1;
	logic signed [63:0] prod_s1;

	// stage one: register operands and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= operation;
			a_s1 <= operand_a;
			b_s1 <= operand_b;
			prod_s1 <= $signed(operand_a) * $signed(operand_b);
		end
	end

	// multiply result from registered product
	logic signed [63:0] mshift;
	logic        mul_ovf;
	assign mshift = prod_s1 >>> FRAC_BITS;
	assign mul_ovf = (mshift[63:31] != {33{1'b0}}) && (mshift[63:31] != {33{1'b1}});

	// float conversion
	logic        fneg;
	logic [7:0]  fexp;
	logic [23:0] fmant;
	logic signed [9:0] fsh;
	logic [55:0] fmag;
	logic        fbig;
	logic [31:0] conv_res;
	assign fneg = a_s1[31];
	assign fexp = a_s1[30:23];
	assign fmant = {1'b1, a_s1[22:0]};
	assign fsh = $signed({2'b00, fexp}) - 10'sd150 + 10'(FRAC_BITS);
	always_comb begin
		fmag = '0;
		fbig = 1'b0;
		if (fsh <= -10'sd25) begin
			fmag = '0;
		end else if (fsh < 10'sd0) begin
			fmag = 56'(fmant) >> 5'(-fsh);
		end else if (fsh > 10'sd8) begin
			fbig = 1'b1;
		end else begin
			fmag = 56'(fmant) << 4'(fsh);
		end
		if (!fbig) begin
			fbig = fneg ? (fmag > 56'h80000000) : (fmag > 56'h7fffffff);
		end
		if (fbig) begin
			conv_res = fneg ? 32'h80000000 : 32'h7fffffff;
		end else begin
			conv_res = fneg ? 32'(-fmag) : fmag[31:0];
		end
	end

	// abs and divide setup
	logic [31:0] ma;
	logic [31:0] mb;
	assign ma = a_s1[31] ? -a_s1 : a_s1;
	assign mb = b_s1[31] ? -b_s1 : b_s1;

	always_comb begin
		dout = '0;
		dout.vld = vld_s1;
		dout.num = {ma, {FRAC_BITS{1'b0}}};
		dout.den = mb;
		dout.neg = a_s1[31] ^ b_s1[31];
		unique case (op_t'(op_s1))
			OP_MUL: begin
				dout.res = mshift[31:0];
				dout.ovf = mul_ovf;
			end
			OP_DIV: begin
				dout.dz = (b_s1[30:0] == 31'd0);
				dout.is_div = !dout.dz;
			end
			OP_CONV: begin
				dout.res = conv_res;
				dout.ovf = fbig;
			end
			OP_ABS: begin
				dout.res = ma;
				dout.ovf = (a_s1 == 32'h80000000);
			end
			default: dout.res = '0;
		endcase
	end

endmodule

// File: src/qalu_cell.sv
// one restoring-division cell: produces one quotient bit per beat
module qalu_cell
	import qalu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t din,
	output cell_t dout
);

	cell_t nxt;
	logic [DW:0] trial;
	logic [DW+1:0] diff;

	// shift in next dividend bit and try subtracting
	always_comb begin
		nxt = din;
		trial = {din.rem[DW-1:0], din.num[NW-1]};
		diff = {1'b0, trial} - {2'b00, din.den};
		nxt.num = {din.num[NW-2:0], 1'b0};
		if (!diff[DW+1]) begin
			nxt.rem = diff[DW:0];
			nxt.quo = {din.quo[NW-2:0], 1'b1};
		end else begin
			nxt.rem = trial;
			nxt.quo = {din.quo[NW-2:0], 1'b0};
		end
	end

	// hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.vld <= 1'b0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// File: src/q16_fixed_point_alu_top.sv
// top level of the q16 fixed point unit: front stage, divider cell row, output skid
// One operation enters per cycle when the pipe can advance: one stage registers
// operands and the multiplier product, then a row of 48 restoring-division cells, one quotient
// bit each, carries every item (divide or not) forward; a two-entry skid buffer at the output
// holds results while the downstream side stalls, and the whole pipe advances when it has room.
// tdata packs operation/operands and result flags from the lowest bit up.
module q16_fixed_point_alu_top
	import qalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[1:0], operand_a[33:2], operand_b[65:34], zero fill to 72
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result[31:0], overflow[32], divide_by_zero[33], zero fill to 40
	output logic [39:0] m_tdata
);

	cell_t chain [NCELL+1];
	logic en;
	logic [1:0] cnt_q;
	logic [33:0] buf_q [2];
	logic rd_q;
	logic [33:0] outv;

	// pipe advances when the skid buffer can take what leaves the row
	assign en = (cnt_q != 2'd2) || m_tready;
	assign s_tready = en;

	qalu_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_tvalid),
		.operation(s_tdata[1:0]), .operand_a(s_tdata[33:2]),
		.operand_b(s_tdata[65:34]), .dout(chain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		qalu_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(chain[i]), .dout(chain[i+1])
		);
	end

	// final divide sign and overflow
	cell_t last;
	logic [NW-1:0] q;
	assign last = chain[NCELL];
	assign q = last.quo;
	always_comb begin
		outv = {last.dz, last.ovf, last.res};
		if (last.is_div) begin
			outv[31:0] = last.neg ? 32'(-q) : q[31:0];
			outv[32] = last.neg ? (q > NW'(33'h80000000)) : (q > NW'(32'h7fffffff));
		end
	end

	// two-entry output fifo
	logic push, pop;
	assign push = en && last.vld;
	assign pop = m_tvalid && m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= 2'(cnt_q + push - pop);
			if (pop) rd_q <= ~rd_q;
		end
	end
	// tail slot sits cnt entries past the head
	always_ff @(posedge clk) begin
		if (push) buf_q[rd_q ^ cnt_q[0]] <= outv;
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata = {6'd0, buf_q[rd_q]};

	// fifo never overfills
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("output fifo overflow");
	// no push into a full fifo without a pop
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q == 2'd2 && push |-> pop)
		else $error("push into full fifo");
	// a divide item never carries the zero flag
	assert property (@(posedge clk) disable iff (!arst_n) last.vld && last.is_div |-> !last.dz)
		else $error("divide flag conflict");

endmodule

// File: test/testbench.sv
// testbench for the q16 fixed point unit: random and directed beats checked against a predictor
module testbench
	import qalu_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_op_t;

	typedef struct {
		logic [31:0] res;
		logic        ovf;
		logic        dz;
	} alu_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	alu_op_t  pending_ops[$];
	alu_res_t expected_results[$];
	int       error_count = 0;
	bit       stim_done = 0;
	int       hold_cycles = 0;
	int       idle_cycles = 0;

	q16_fixed_point_alu_top dut (.*);

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// q16 arithmetic predictor
	function automatic alu_res_t predict_alu(alu_op_t it);
		alu_res_t r;
		logic signed [63:0] prod;
		logic signed [63:0] sh;
		logic [63:0] ma, mb, q, mag, mant;
		logic neg;
		int e, s;
		r.res = 0;
		r.ovf = 0;
		r.dz = 0;
		case (it.op)
			OP_MUL: begin
				prod = $signed(it.a) * $signed(it.b);
				sh = prod >>> FRAC_BITS;
				r.res = sh[31:0];
				r.ovf = (sh > 64'sh7fffffff) || (sh < -64'sh80000000);
			end
			OP_DIV: begin
				if (it.b[30:0] == 0) begin
					r.dz = 1;
				end else begin
					ma = it.a[31] ? {32'b0, -it.a} : {32'b0, it.a};
					mb = it.b[31] ? {32'b0, -it.b} : {32'b0, it.b};
					q = (ma << FRAC_BITS) / mb;
					if (it.a[31] != it.b[31]) begin
						r.res = -q[31:0];
						r.ovf = q > 64'h80000000;
					end else begin
						r.res = q[31:0];
						r.ovf = q > 64'h7fffffff;
					end
				end
			end
			OP_CONV: begin
				neg = it.a[31];
				e = it.a[30:23];
				mant = {40'b0, 1'b1, it.a[22:0]};
				s = e - 150 + FRAC_BITS;
				if (s <= -25) mag = 0;
				else if (s < 0) mag = mant >> (-s);
				else if (s > 8) mag = 64'hffffffffff;
				else mag = mant << s;
				if (neg ? mag > 64'h80000000 : mag > 64'h7fffffff) begin
					r.res = neg ? 32'h80000000 : 32'h7fffffff;
					r.ovf = 1;
				end else begin
					r.res = neg ? -mag[31:0] : mag[31:0];
				end
			end
			default: begin
				r.res = it.a[31] ? -it.a : it.a;
				r.ovf = it.a == 32'h80000000;
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return 32'h80000000 + $urandom_range(0, 3) - 1;
			1: return $urandom_range(0, 3) - 1;
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			3: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)} << $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(op_t op, logic [31:0] a, logic [31:0] b);
		alu_op_t it;
		it.op = op;
		it.a = a;
		it.b = b;
		pending_ops.push_back(it);
	endtask

	// stimulus
	initial begin
		logic [31:0] fa;
		add_op(OP_MUL, 32'h7fffffff, 32'h7fffffff);
		add_op(OP_MUL, 32'h80000000, 32'h80000000);
		add_op(OP_MUL, 32'h80000000, 32'h00010000);
		add_op(OP_MUL, 32'hffffffff, 32'h00000001);
		add_op(OP_DIV, 32'h00010000, 32'h00000000);
		add_op(OP_DIV, 32'h12345678, 32'h80000000);
		add_op(OP_DIV, 32'h80000000, 32'h00000001);
		add_op(OP_DIV, 32'h80000000, 32'hffffffff);
		add_op(OP_DIV, 32'h7fffffff, 32'h7fffffff);
		add_op(OP_DIV, 32'h00008000, 32'hffff0000);
		add_op(OP_CONV, 32'h00000000, 32'h0);
		add_op(OP_CONV, 32'h80000000, 32'h0);
		add_op(OP_CONV, 32'h00400001, 32'h0);
		add_op(OP_CONV, 32'h7f800000, 32'h0);
		add_op(OP_CONV, 32'hff800000, 32'h0);
		add_op(OP_CONV, 32'h7fc00000, 32'h0);
		add_op(OP_CONV, 32'h47000000, 32'h0);
		add_op(OP_CONV, 32'hc7000000, 32'h0);
		add_op(OP_CONV, 32'h3f800000, 32'hffffffff);
		add_op(OP_CONV, 32'hbfc00000, 32'h0);
		add_op(OP_ABS, 32'h80000000, 32'h0);
		add_op(OP_ABS, 32'h7fffffff, 32'h0);
		add_op(OP_ABS, 32'hffffffff, 32'h0);
		add_op(OP_ABS, 32'h00000000, 32'h0);
		for (int i = 0; i < 1800; i++) begin
			if ($urandom_range(0, 3) == 0) fa = $urandom;
			else fa = {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
			case ($urandom_range(0, 3))
				0: add_op(OP_MUL, pick_operand(), pick_operand());
				1: add_op(OP_DIV, pick_operand(), pick_operand());
				2: add_op(OP_CONV, fa, $urandom);
				default: add_op(OP_ABS, pick_operand(), $urandom);
			endcase
		end
		stim_done = 1;
	end

	// driver: the accepted beat leaves the queue, the next one is its new head
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= 0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) expected_results.push_back(predict_alu(pending_ops.pop_front()));
			if (src_gap > 0) begin
				s_tvalid <= 0;
				src_gap <= src_gap - 1;
			end else if (pending_ops.size() > 0) begin
				s_tvalid <= 1;
				s_tdata <= {6'b0, pending_ops[0].b, pending_ops[0].a, pending_ops[0].op};
				src_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// monitor and receiver stalls, with one long hold-off
	int dst_gap = 0;
	bit long_hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		alu_res_t want;
		if (!arst_n) begin
			m_tready <= 0;
			dst_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result actual=%h", $time, m_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.res || m_tdata[32] !== want.ovf ||
					    m_tdata[33] !== want.dz) begin
						$display("%0t: mismatch expected res=%h ovf=%b dz=%b actual res=%h ovf=%b dz=%b",
							$time, want.res, want.ovf, want.dz,
							m_tdata[31:0], m_tdata[32], m_tdata[33]);
						error_count++;
					end
				end
			end
			if (!long_hold_done && expected_results.size() > 10) begin
				long_hold_done <= 1;
				hold_cycles <= 200;
				m_tready <= 0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 0;
			end else if (dst_gap > 0) begin
				dst_gap <= dst_gap - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				dst_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (stim_done);
		fork
			begin
				wait (pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0);
				repeat (60) @(posedge clk);
			end
			wait (idle_cycles > 2000);
		join_any
		if (idle_cycles > 2000) begin
			$display("TB_ERROR");
		end else if (error_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
